// ===== rtl/core/gha_pkg.sv =====
// Shared types and constants for the generational handle allocator.
// Holds the stream word layouts, command codes and the controller/datapath links.
// Depends on nothing.
package gha_pkg;

	localparam int IN_TDATA_W  = 104;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_TUSER_W = 1;
	localparam int GEN_W       = 32;
	localparam int SLOT_FIELD_W = 16;
	localparam int STRIDE_W    = 18;
	localparam int SLOT_OUT_W  = 6;

	localparam logic [1:0] CMD_CREATE     = 2'd0;
	localparam logic [1:0] CMD_DESTROY    = 2'd1;
	localparam logic [1:0] CMD_MARK_DIRTY = 2'd2;

	localparam logic [GEN_W-1:0] GEN_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [5:0]              pad;
		logic [STRIDE_W-1:0]     stride;
		logic [15:0]             height;
		logic [15:0]             width;
		logic [47:0]             handle;
	} in_data_t;

	typedef struct packed {
		logic [STRIDE_W-1:0]     effective_stride;
		logic [SLOT_OUT_W-1:0]   slot_index;
		logic [47:0]             new_handle;
	} out_data_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic pick;
		logic read;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic create_ok;
		logic lookup;
		logic out_free;
		logic slot_used;
		logic slot_dirty;
	} dp_status_t;

endpackage

// ===== rtl/core/gha_ctrl.sv =====
// Sequencing state machine for the generational handle allocator.
// Drives the datapath commands and the input ready; uses gha_pkg.
module gha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gha_pkg::dp_status_t sts,
	output gha_pkg::ctrl_cmd_t  cmd
);
	import gha_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_PICK = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_EXEC = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.create_ok) begin
						state_d = ST_SCAN;
					end else if (sts.lookup) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/gha_datapath.sv =====
// Slot table, free-slot search, generation memory and result register.
// Acts on commands from gha_ctrl; uses gha_pkg.
module gha_datapath #(
	parameter int NUM_SLOTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [gha_pkg::IN_TDATA_W-1:0]      in_tdata,
	input  logic [gha_pkg::IN_TUSER_W-1:0]      in_tuser,
	input  gha_pkg::ctrl_cmd_t                  cmd,
	output gha_pkg::dp_status_t                 sts,
	output logic                                out_tvalid,
	input  logic                                out_tready,
	output logic [gha_pkg::OUT_TDATA_W-1:0]     out_tdata,
	output logic [gha_pkg::OUT_TUSER_W-1:0]     out_tuser
);
	import gha_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int NG = (NUM_SLOTS + 7) / 8;

	in_data_t in_word;
	assign in_word = in_data_t'(in_tdata);

	logic [NUM_SLOTS-1:0] used_q;
	logic [NUM_SLOTS-1:0] dirty_q;
	logic [NUM_SLOTS-1:0] retired_q;
	logic [NUM_SLOTS-1:0] gen_valid_q;
	logic [GEN_W-1:0]     gen_mem [NUM_SLOTS];
	logic [GEN_W-1:0]     rd_gen_q;

	logic [1:0]          cmd_q;
	logic                create_ok_q;
	logic                lookup_q;
	logic                handle_ok_q;
	logic [GEN_W-1:0]    hgen_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [IW-1:0]       slot_q;
	logic                found_q;

	logic [NG-1:0]       grp_any_q;
	logic [2:0]          grp_idx_q [NG];
	logic [NG-1:0]       grp_any_d;
	logic [2:0]          grp_idx_d [NG];
	logic [NG*8-1:0]     free_pad;
	logic                pick_found;
	logic [IW-1:0]       pick_slot;

	logic                out_valid_q;
	out_data_t           out_word_q;
	logic                out_status_q;

	logic                     in_create_ok;
	logic                     in_lookup;
	logic [SLOT_FIELD_W-1:0]  in_slot_field;
	logic                     in_range_ok;
	logic [SLOT_FIELD_W-1:0]  in_slot_m1;
	logic [GEN_W-1:0]         eff_gen;
	logic [GEN_W-1:0]         new_gen;
	logic                     create_go;
	logic                     lookup_go;
	logic [SLOT_FIELD_W-1:0]  slot_ext;

	assign in_create_ok  = (in_tuser == CMD_CREATE) && (in_word.width != '0) &&
	                       (in_word.height != '0);
	assign in_lookup     = (in_tuser == CMD_DESTROY) || (in_tuser == CMD_MARK_DIRTY);
	assign in_slot_field = in_word.handle[SLOT_FIELD_W-1:0];
	assign in_range_ok   = (in_slot_field != '0) &&
	                       ({1'b0, in_slot_field} <= 17'(NUM_SLOTS)) &&
	                       (in_word.handle[47:SLOT_FIELD_W] != '0);
	assign in_slot_m1    = in_slot_field - 16'd1;

	assign free_pad = (NG*8)'(~used_q & ~retired_q);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any_d[g] = 1'b0;
			grp_idx_d[g] = 3'd0;
			for (int b = 7; b >= 0; b--) begin
				if (free_pad[g*8 + b]) begin
					grp_any_d[g] = 1'b1;
					grp_idx_d[g] = 3'(b);
				end
			end
		end
	end

	always_comb begin
		pick_found = 1'b0;
		pick_slot  = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				pick_found = 1'b1;
				pick_slot  = IW'(g*8 + int'(grp_idx_q[g]));
			end
		end
	end

	assign eff_gen   = gen_valid_q[slot_q] ? rd_gen_q : '0;
	assign new_gen   = eff_gen + 32'd1;
	assign create_go = create_ok_q && found_q;
	assign lookup_go = lookup_q && handle_ok_q && used_q[slot_q] && (eff_gen == hgen_q);
	assign slot_ext  = SLOT_FIELD_W'(slot_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q       <= in_tuser;
			create_ok_q <= in_create_ok;
			lookup_q    <= in_lookup;
			handle_ok_q <= in_range_ok;
			hgen_q      <= in_word.handle[47:SLOT_FIELD_W];
			stride_q    <= (in_word.stride != '0) ? in_word.stride : {in_word.width, 2'b00};
		end
		if (cmd.scan) begin
			grp_idx_q <= grp_idx_d;
		end
		if (cmd.read) begin
			rd_gen_q <= gen_mem[slot_q];
		end
		if (cmd.exec && create_go) begin
			gen_mem[slot_q] <= new_gen;
		end
		if (cmd.exec) begin
			out_status_q               <= !(create_go || lookup_go);
			out_word_q.new_handle      <= create_go ? {new_gen, slot_ext + 16'd1} : '0;
			out_word_q.slot_index      <= (create_go || lookup_go) ?
			                              slot_ext[SLOT_OUT_W-1:0] : '0;
			out_word_q.effective_stride <= create_go ? stride_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			dirty_q     <= '0;
			retired_q   <= '0;
			gen_valid_q <= '0;
			grp_any_q   <= '0;
			slot_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				slot_q  <= in_range_ok ? in_slot_m1[IW-1:0] : '0;
				found_q <= 1'b0;
			end
			if (cmd.scan) begin
				grp_any_q <= grp_any_d;
			end
			if (cmd.pick) begin
				slot_q  <= pick_slot;
				found_q <= pick_found;
			end
			if (cmd.exec) begin
				if (create_go) begin
					used_q[slot_q]      <= 1'b1;
					dirty_q[slot_q]     <= 1'b1;
					gen_valid_q[slot_q] <= 1'b1;
					retired_q[slot_q]   <= (new_gen == GEN_MAX);
				end else if (lookup_go) begin
					if (cmd_q == CMD_DESTROY) begin
						used_q[slot_q] <= 1'b0;
					end else begin
						dirty_q[slot_q] <= 1'b1;
					end
				end
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.create_ok  = in_create_ok;
	assign sts.lookup     = in_lookup;
	assign sts.out_free   = !out_valid_q || out_tready;
	assign sts.slot_used  = used_q[slot_q];
	assign sts.slot_dirty = dirty_q[slot_q];

	assign out_tvalid = out_valid_q;
	assign out_tdata  = OUT_TDATA_W'(out_word_q);
	assign out_tuser  = out_status_q;

endmodule

// ===== rtl/core/generational_handle_allocator.sv =====
// Top level of the generational handle allocator: stream ports, controller and datapath.
// Instantiates gha_ctrl and gha_datapath; uses gha_pkg.
//
// One command word is taken at a time. A create is accepted, scans the free map in groups of
// eight, picks the first free slot, reads its generation from the generation memory and then
// updates it, passing through the scan, pick, read and exec states; exec waits while the output
// register is full and not being taken. Destroy and mark dirty skip the search and need one
// generation read. A create with zero width or height and an unknown command fail at once.
// The output register lets a new word start while the previous result still waits. Slot state
// lives in flip-flops that reset clears, so there is no clearing pass after reset.
module generational_handle_allocator #(
	parameter int NUM_SLOTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// handle[47:0], width[63:48], height[79:64], stride[97:80], zero pad[103:98]
	input  logic [gha_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// command[1:0]
	input  logic [gha_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// new_handle[47:0], slot_index[53:48], effective_stride[71:54]
	output logic [gha_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// status[0]
	output logic [gha_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
	import gha_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gha_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser)
	);

	// A failed word carries no handle, slot or stride.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("failed result carries nonzero fields");

	// An issued handle names the reported slot and a nonzero generation.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata[47:0] != '0 |->
		m_axis_tdata[47:16] != '0 &&
		6'(m_axis_tdata[15:0] - 16'd1) == m_axis_tdata[53:48])
		else $error("issued handle does not match slot index");

	// Work on one word at a time: no second word right after an accepted one.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a word is in progress");

	// Nothing clears a dirty bit, so every live slot is dirty.
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.slot_used |-> sts.slot_dirty)
		else $error("live slot without dirty bit");

endmodule
